// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ID3_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define ID3_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/id3_pkg.sv -----
// ----------------------------------------------------------------------------
// id3_pkg
// Types, constants and helper functions shared by the ID3v2 tag frame parser.
// ----------------------------------------------------------------------------
package id3_pkg;

   localparam int unsigned FRAME_SIZE_BITS_DEFAULT = 32;

   // Tag header layout.
   localparam logic [23:0] ID3_MAGIC        = 24'h494433;
   localparam logic [3:0]  HDR_MAGIC_BYTES  = 4'd3;
   localparam logic [3:0]  HDR_SIZE_FIRST   = 4'd6;
   localparam logic [3:0]  HDR_LAST         = 4'd9;
   localparam logic [31:0] TAG_HEADER_BYTES = 32'd10;

   // Frame header layout.
   localparam logic [3:0]  FHDR_ID_BYTES    = 4'd4;
   localparam logic [3:0]  FHDR_SIZE_END    = 4'd8;

   // Matched frame codes.
   localparam logic [2:0]  TAG_TIT2     = 3'd0;
   localparam logic [2:0]  TAG_TPE1     = 3'd1;
   localparam logic [2:0]  TAG_TALB     = 3'd2;
   localparam logic [2:0]  TAG_TYER     = 3'd3;
   localparam logic [2:0]  TAG_TCON     = 3'd4;
   localparam logic [2:0]  TAG_COMM     = 3'd5;
   localparam logic [2:0]  TAG_NO_MATCH = 3'd6;
   localparam int unsigned NUM_TAGS     = 6;

   localparam logic [31:0] KNOWN_IDS [NUM_TAGS] = '{
      32'h54495432,   // TIT2
      32'h54504531,   // TPE1
      32'h54414C42,   // TALB
      32'h54594552,   // TYER
      32'h54434F4E,   // TCON
      32'h434F4D4D    // COMM
   };

   // Result part codes.
   localparam logic [1:0] PART_TEXT      = 2'd0;
   localparam logic [1:0] PART_LANGUAGE  = 2'd1;
   localparam logic [1:0] PART_BODY      = 2'd2;

   // Comment walk codes.
   localparam logic [1:0] CPART_LANGUAGE = 2'd0;
   localparam logic [1:0] CPART_DESCR    = 2'd1;
   localparam logic [1:0] CPART_BODY     = 2'd2;

   localparam int unsigned COMM_LANG_LAST = 3;
   localparam int unsigned COMM_MIN_SIZE  = 4;

   localparam logic STATUS_CONTENT = 1'b0;
   localparam logic STATUS_NO_TAG  = 1'b1;

   // Queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH      = 2;
   localparam int unsigned QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned RSP_TUSER_BITS = 7;

   typedef enum logic [3:0] {
      PH_HEADER       = 4'b0001,
      PH_FRAME_HEADER = 4'b0010,
      PH_FRAME_DATA   = 4'b0100,
      PH_DONE         = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       status;
      logic [2:0] tag_index;
      logic [1:0] part;
      logic       has_char;
      logic [7:0] char_byte;
      logic       last;
   } rsp_event_type;

   typedef struct packed {
      logic          valid;
      rsp_event_type evt;
   } queue_entry_type;

   // Maps a frame identifier to its tag code, or to no match.
   function automatic logic [2:0] match_tag(input logic [31:0] ident);
      logic [2:0] code;
      code = TAG_NO_MATCH;
      for (int k = NUM_TAGS - 1; k >= 0; k--) begin
         if (ident == KNOWN_IDS[k]) begin
            code = 3'(k);
         end
      end
      return code;
   endfunction

endpackage

// ----- sv/id3_front.sv -----
// ----------------------------------------------------------------------------
// id3_front
// Byte parser: walks the tag header and frame headers and classifies each
// frame data byte, pushing at most one result event per request.
// ----------------------------------------------------------------------------
module id3_front #(
   parameter int unsigned FRAME_SIZE_BITS = id3_pkg::FRAME_SIZE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                data_byte,
   input  logic                      start_of_file,
   input  logic                      queue_full,
   output id3_pkg::queue_entry_type  push
);
   import id3_pkg::*;

   phase_type                  phase_ff, phase_in;
   logic [3:0]                 hdr_count_ff, hdr_count_in;
   logic [31:0]                tag_end_ff, tag_end_in;
   logic [31:0]                stream_pos_ff, stream_pos_in;
   logic [31:0]                ident_ff, ident_in;
   logic [FRAME_SIZE_BITS-1:0] frame_len_ff, frame_len_in;
   logic [FRAME_SIZE_BITS-1:0] frame_last_ff, frame_last_in;
   logic [FRAME_SIZE_BITS-1:0] frame_off_ff, frame_off_in;
   logic [2:0]                 matched_ff, matched_in;
   logic [1:0]                 cpart_ff, cpart_in;
   logic                       qualifies_ff, qualifies_in;

   // View of the state after a start of file has been applied.
   phase_type   cur_phase;
   logic [3:0]  cur_count;
   logic [31:0] cur_tag_end;
   logic [31:0] cur_pos;
   logic [31:0] cur_id;
   logic [31:0] pos_inc;
   logic [31:0] tag_end_shift;
   logic [2:0]  tag_code;
   logic        accept;
   logic        is_last;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   assign cur_phase   = start_of_file ? PH_HEADER : phase_ff;
   assign cur_count   = start_of_file ? 4'd0      : hdr_count_ff;
   assign cur_tag_end = start_of_file ? 32'd0     : tag_end_ff;
   assign cur_pos     = start_of_file ? 32'd0     : stream_pos_ff;
   assign cur_id      = start_of_file ? 32'd0     : ident_ff;

   assign pos_inc       = cur_pos + 32'd1;
   assign tag_end_shift = {cur_tag_end[24:0], data_byte[6:0]};
   assign tag_code      = match_tag(ident_ff);
   assign is_last       = (frame_off_ff == frame_last_ff);

   always_comb begin
      phase_in      = phase_ff;
      hdr_count_in  = hdr_count_ff;
      tag_end_in    = tag_end_ff;
      stream_pos_in = stream_pos_ff;
      ident_in      = ident_ff;
      frame_len_in  = frame_len_ff;
      frame_last_in = frame_last_ff;
      frame_off_in  = frame_off_ff;
      matched_in    = matched_ff;
      cpart_in      = cpart_ff;
      qualifies_in  = qualifies_ff;
      push          = '0;

      if (accept) begin
         if (start_of_file) begin
            frame_len_in = '0;
            frame_off_in = '0;
            matched_in   = TAG_NO_MATCH;
            cpart_in     = CPART_LANGUAGE;
         end
         case (cur_phase)
            PH_HEADER: begin
               phase_in      = PH_HEADER;
               tag_end_in    = cur_tag_end;
               ident_in      = cur_id;
               stream_pos_in = pos_inc;
               if (cur_count < HDR_MAGIC_BYTES) begin
                  ident_in = {cur_id[23:0], data_byte};
               end else if (cur_count >= HDR_SIZE_FIRST) begin
                  tag_end_in = tag_end_shift;
               end
               if (cur_count >= HDR_LAST) begin
                  if (cur_id[23:0] != ID3_MAGIC) begin
                     phase_in         = PH_DONE;
                     hdr_count_in     = cur_count;
                     push.valid       = 1'b1;
                     push.evt.status  = STATUS_NO_TAG;
                  end else begin
                     tag_end_in   = tag_end_shift + TAG_HEADER_BYTES;
                     ident_in     = '0;
                     hdr_count_in = '0;
                     phase_in     = (pos_inc < tag_end_in) ? PH_FRAME_HEADER : PH_DONE;
                  end
               end else begin
                  hdr_count_in = cur_count + 4'd1;
               end
            end

            PH_FRAME_HEADER: begin
               stream_pos_in = pos_inc;
               if (hdr_count_ff < FHDR_ID_BYTES) begin
                  ident_in = {ident_ff[23:0], data_byte};
               end else if (hdr_count_ff < FHDR_SIZE_END) begin
                  frame_len_in = (frame_len_ff << 8) | FRAME_SIZE_BITS'(data_byte);
               end
               if (hdr_count_ff >= HDR_LAST) begin
                  if (frame_len_ff == '0) begin
                     phase_in = PH_DONE;
                  end else begin
                     matched_in    = tag_code;
                     frame_last_in = frame_len_ff - FRAME_SIZE_BITS'(1);
                     qualifies_in  =
                        (tag_code < TAG_COMM && frame_len_ff > FRAME_SIZE_BITS'(1)) ||
                        (tag_code == TAG_COMM &&
                         frame_len_ff > FRAME_SIZE_BITS'(COMM_MIN_SIZE));
                     frame_off_in  = '0;
                     cpart_in      = CPART_LANGUAGE;
                     hdr_count_in  = '0;
                     phase_in      = PH_FRAME_DATA;
                  end
               end else begin
                  hdr_count_in = hdr_count_ff + 4'd1;
               end
            end

            PH_FRAME_DATA: begin
               stream_pos_in = pos_inc;
               frame_off_in  = frame_off_ff + FRAME_SIZE_BITS'(1);
               if (qualifies_ff && frame_off_ff != '0) begin
                  push.evt.status    = STATUS_CONTENT;
                  push.evt.tag_index = matched_ff;
                  push.evt.last      = is_last;
                  if (matched_ff < TAG_COMM) begin
                     push.valid         = 1'b1;
                     push.evt.part      = PART_TEXT;
                     push.evt.has_char  = 1'b1;
                     push.evt.char_byte = data_byte;
                  end else if (frame_off_ff <= FRAME_SIZE_BITS'(COMM_LANG_LAST)) begin
                     push.valid         = 1'b1;
                     push.evt.part      = PART_LANGUAGE;
                     push.evt.has_char  = 1'b1;
                     push.evt.char_byte = data_byte;
                  end else if (cpart_ff == CPART_BODY) begin
                     push.valid         = 1'b1;
                     push.evt.part      = PART_BODY;
                     push.evt.has_char  = 1'b1;
                     push.evt.char_byte = data_byte;
                  end else begin
                     // Description bytes are dropped; the final byte still closes
                     // the frame with an empty marker result.
                     cpart_in          = (data_byte == 8'd0) ? CPART_BODY : CPART_DESCR;
                     push.valid        = is_last;
                     push.evt.part     = PART_BODY;
                  end
               end
               if (is_last) begin
                  hdr_count_in = '0;
                  phase_in     = (pos_inc < tag_end_ff) ? PH_FRAME_HEADER : PH_DONE;
               end
            end

            PH_DONE: begin
               phase_in = PH_DONE;
            end

            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         hdr_count_ff  <= '0;
         tag_end_ff    <= '0;
         stream_pos_ff <= '0;
         ident_ff      <= '0;
         frame_len_ff  <= '0;
         frame_last_ff <= '0;
         frame_off_ff  <= '0;
         matched_ff    <= TAG_NO_MATCH;
         cpart_ff      <= CPART_LANGUAGE;
         qualifies_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         hdr_count_ff  <= hdr_count_in;
         tag_end_ff    <= tag_end_in;
         stream_pos_ff <= stream_pos_in;
         ident_ff      <= ident_in;
         frame_len_ff  <= frame_len_in;
         frame_last_ff <= frame_last_in;
         frame_off_ff  <= frame_off_in;
         matched_ff    <= matched_in;
         cpart_ff      <= cpart_in;
         qualifies_ff  <= qualifies_in;
      end
   end

endmodule

// ----- sv/id3_queue.sv -----
// ----------------------------------------------------------------------------
// id3_queue
// Short first-in first-out queue of result events between front and back.
// ----------------------------------------------------------------------------
module id3_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  id3_pkg::queue_entry_type  push,
   output logic                      full,
   output id3_pkg::queue_entry_type  head,
   input  logic                      pop
);
   import id3_pkg::*;

   rsp_event_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   localparam logic [QUEUE_PTR_BITS-1:0] PTR_LAST = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_COUNT_BITS-1:0] COUNT_FULL = QUEUE_COUNT_BITS'(QUEUE_DEPTH);

   assign full       = (count_ff == COUNT_FULL);
   assign head.valid = (count_ff != '0);
   assign head.evt   = entries_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.evt;
      end
   end

endmodule

// ----- sv/id3_back.sv -----
// ----------------------------------------------------------------------------
// id3_back
// Output stage: takes events from the queue into the result register and
// formats them onto the result channel.
// ----------------------------------------------------------------------------
module id3_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  id3_pkg::queue_entry_type              head,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,
   output logic [id3_pkg::RSP_TUSER_BITS-1:0]    rsp_tuser,
   output logic                                  rsp_tlast
);
   import id3_pkg::*;

   logic          out_valid_ff, out_valid_in;
   rsp_event_type out_evt_ff;

   // A held result is replaced in the same cycle that it is taken.
   assign pop = head.valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_evt_ff <= head.evt;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_evt_ff.char_byte;
   assign rsp_tuser  = {out_evt_ff.has_char, out_evt_ff.part,
                        out_evt_ff.tag_index, out_evt_ff.status};
   assign rsp_tlast  = out_evt_ff.last;

endmodule

// ----- sv/id3v2_tag_frame_parser.sv -----
// ----------------------------------------------------------------------------
// id3v2_tag_frame_parser
// ID3v2.3 tag parser that extracts the text of common frames from a file
// given one byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: one file byte per request in req_tdata; req_tuser high
//   marks the first byte of a new file and restarts the parser on that byte.
//   Result channel: zero or one result per request. rsp_tdata carries the
//   content byte, rsp_tuser the status, frame code, part and has-char flag,
//   rsp_tlast the final byte of a qualifying frame. A missing ID3 tag gives
//   one result with status set at the tenth header byte.
//   Throughput: one byte per cycle while the event queue is not full.
//   Each result is written into the event queue when its request is taken
//   and moves on from there into the output register that drives
//   rsp_tvalid; it then sits in the output register until it is taken.
//   Reset clears the parser to the tag header phase and empties the queue
//   and the output register.
//   When the receiver stalls, the output register holds its result, the
//   two-entry queue fills, and req_tready falls once the queue is full.
// ----------------------------------------------------------------------------
module id3v2_tag_frame_parser #(
   parameter int unsigned FRAME_SIZE_BITS = id3_pkg::FRAME_SIZE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] data_byte
   input  logic                               req_tuser,   // [0] start_of_file
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,   // [7:0] char_byte
   // [0] status, [3:1] tag_index, [5:4] part, [6] has_char
   output logic [id3_pkg::RSP_TUSER_BITS-1:0] rsp_tuser,
   output logic                               rsp_tlast    // last
);
   import id3_pkg::*;

   queue_entry_type push;
   queue_entry_type head;
   logic            queue_full;
   logic            pop;

   id3_front #(
      .FRAME_SIZE_BITS (FRAME_SIZE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .data_byte     (req_tdata),
      .start_of_file (req_tuser),
      .queue_full    (queue_full),
      .push          (push)
   );

   id3_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   id3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- sv/id3_checker.sv -----
// ----------------------------------------------------------------------------
// id3_checker
// Port-level assertions for the ID3v2 tag frame parser, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module id3_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [7:0]                         rsp_tdata,
   input logic [id3_pkg::RSP_TUSER_BITS-1:0] rsp_tuser,
   input logic                               rsp_tlast
);
   import id3_pkg::*;

   // A stalled result keeps its contents.
   `ID3_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result changed while stalled")

   // A missing-tag result carries nothing else.
   `ID3_ASSERT(a_no_tag_clean, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[6:1] == '0 && rsp_tdata == 8'd0 && !rsp_tlast, "missing-tag result has stray fields")

   // Content results name a known frame and a known part.
   `ID3_ASSERT(a_codes_known, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tuser[3:1] != TAG_NO_MATCH && rsp_tuser[3:1] != 3'd7 && rsp_tuser[5:4] != 2'd3, "unknown frame or part code")

   // A result without a character only closes a comment frame.
   `ID3_ASSERT(a_empty_closes, clock, reset, rsp_tvalid && !rsp_tuser[0] && !rsp_tuser[6] |-> rsp_tlast && rsp_tuser[5:4] == PART_BODY && rsp_tuser[3:1] == TAG_COMM && rsp_tdata == 8'd0, "empty result is not a comment frame end")

   // Reset empties the output.
   `ID3_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind id3v2_tag_frame_parser id3_checker u_checker (.*);

// ----- test/tag_event_sb_pkg.sv -----
// ----------------------------------------------------------------------------
// tag_event_sb_pkg
// Scoreboard for the ID3v2 tag frame parser: it walks each accepted request
// through its own copy of the parser state, queues the result events that
// the byte should cause, and checks every result against the oldest of them.
// ----------------------------------------------------------------------------
package tag_event_sb_pkg;

   import id3_pkg::*;

   localparam int unsigned REPORT_LIMIT = 10;

   class tag_event_scoreboard;

      phase_type     walk_phase;
      logic [3:0]    byte_index;
      logic [31:0]   tag_end;
      logic [31:0]   byte_count;
      logic [31:0]   ident;
      logic [31:0]   frame_len;
      logic [31:0]   frame_off;
      logic [2:0]    frame_code;
      logic [1:0]    comm_walk;
      rsp_event_type pending_events[$];
      int unsigned   error_count;

      function new();
         restart();
         error_count = 0;
      endfunction

      function void restart();
         walk_phase = PH_HEADER;
         byte_index = '0;
         tag_end    = '0;
         byte_count = '0;
         ident      = '0;
         frame_len  = '0;
         frame_off  = '0;
         frame_code = TAG_NO_MATCH;
         comm_walk  = CPART_LANGUAGE;
      endfunction

      function void next_frame_or_stop();
         byte_index = '0;
         walk_phase = (byte_count < tag_end) ? PH_FRAME_HEADER : PH_DONE;
      endfunction

      function string describe(rsp_event_type e);
         return $sformatf("status=%0d tag=%0d part=%0d has_char=%0d char=%02h last=%0d",
                          e.status, e.tag_index, e.part, e.has_char, e.char_byte, e.last);
      endfunction

      // Steps the parser by one accepted request. Returns 0 when the byte
      // was simply ignored because parsing had already stopped.
      function bit note_byte(logic [7:0] b, logic sof);
         rsp_event_type evt;
         logic [31:0]   off;
         bit            at_end;
         bit            qualifies;
         bit            content;
         bit            found;
         logic [1:0]    prt;
         bit            live;
         if (sof) begin
            restart();
         end
         live = (walk_phase != PH_DONE);
         evt  = '0;
         case (walk_phase)
            PH_HEADER: begin
               if (byte_index < HDR_MAGIC_BYTES) begin
                  ident = {ident[23:0], b};
               end else if (byte_index >= HDR_SIZE_FIRST) begin
                  tag_end = {tag_end[24:0], b[6:0]};
               end
               byte_count++;
               if (byte_index >= HDR_LAST) begin
                  if (ident[23:0] != ID3_MAGIC) begin
                     walk_phase = PH_DONE;
                     evt.status = STATUS_NO_TAG;
                     pending_events.push_back(evt);
                  end else begin
                     tag_end = tag_end + TAG_HEADER_BYTES;
                     ident   = '0;
                     next_frame_or_stop();
                  end
               end else begin
                  byte_index++;
               end
            end
            PH_FRAME_HEADER: begin
               if (byte_index < FHDR_ID_BYTES) begin
                  ident = {ident[23:0], b};
               end else if (byte_index < FHDR_SIZE_END) begin
                  frame_len = {frame_len[23:0], b};
               end
               byte_count++;
               if (byte_index >= HDR_LAST) begin
                  frame_len = frame_len &
                              32'((64'd1 << FRAME_SIZE_BITS_DEFAULT) - 64'd1);
                  if (frame_len == 0) begin
                     walk_phase = PH_DONE;
                  end else begin
                     frame_code = TAG_NO_MATCH;
                     found      = 1'b0;
                     for (int k = 0; k < NUM_TAGS; k++) begin
                        if (!found && ident == KNOWN_IDS[k]) begin
                           frame_code = k[2:0];
                           found      = 1'b1;
                        end
                     end
                     frame_off  = '0;
                     comm_walk  = CPART_LANGUAGE;
                     byte_index = '0;
                     walk_phase = PH_FRAME_DATA;
                  end
               end else begin
                  byte_index++;
               end
            end
            PH_FRAME_DATA: begin
               off       = frame_off;
               at_end    = (off == frame_len - 32'd1);
               qualifies = (frame_code < TAG_COMM && frame_len > 1) ||
                           (frame_code == TAG_COMM && frame_len > COMM_MIN_SIZE);
               byte_count++;
               frame_off++;
               if (qualifies && off != 0) begin
                  content = 1'b0;
                  prt     = PART_TEXT;
                  if (frame_code < TAG_COMM) begin
                     content = 1'b1;
                  end else if (off <= COMM_LANG_LAST) begin
                     content = 1'b1;
                     prt     = PART_LANGUAGE;
                  end else if (comm_walk == CPART_BODY) begin
                     content = 1'b1;
                     prt     = PART_BODY;
                  end else begin
                     // The zero byte closes the description; the body follows.
                     comm_walk = (b == 8'd0) ? CPART_BODY : CPART_DESCR;
                  end
                  if (content || at_end) begin
                     evt.status    = STATUS_CONTENT;
                     evt.tag_index = frame_code;
                     evt.part      = content ? prt : PART_BODY;
                     evt.has_char  = content;
                     evt.char_byte = content ? b : 8'd0;
                     evt.last      = at_end;
                     pending_events.push_back(evt);
                  end
               end
               if (at_end) begin
                  next_frame_or_stop();
               end
            end
            default: begin
            end
         endcase
         return live;
      endfunction

      function void check_event(rsp_event_type got);
         rsp_event_type want;
         if (pending_events.size() == 0) begin
            if (error_count < REPORT_LIMIT) begin
               $display("%0t: result with nothing expected: %s", $time, describe(got));
            end
            error_count++;
         end else begin
            want = pending_events.pop_front();
            if (got.status !== want.status || got.tag_index !== want.tag_index ||
                got.part !== want.part || got.has_char !== want.has_char ||
                got.char_byte !== want.char_byte || got.last !== want.last) begin
               if (error_count < REPORT_LIMIT) begin
                  $display("%0t: result mismatch", $time);
                  $display("   expected %s", describe(want));
                  $display("   actual   %s", describe(got));
               end
               error_count++;
            end
         end
      endfunction

      function int unsigned pending();
         return pending_events.size();
      endfunction

      function int unsigned final_errors();
         if (pending_events.size() != 0) begin
            $display("%0d expected results never arrived, oldest: %s",
                     pending_events.size(), describe(pending_events[0]));
         end
         return error_count + pending_events.size();
      endfunction

   endclass

endpackage

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives byte streams of ID3v2 files into the tag frame parser: a few
// hand-made headers first, then random files with text and comment frames,
// near-miss identifiers, short, empty and truncated frames, odd tag sizes
// and some noise, with random idling on both sides and one long stall of the
// result side. Every result is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import id3_pkg::*;
   import tag_event_sb_pkg::*;

   localparam int unsigned TARGET_BYTES    = 950;
   localparam int unsigned QUIET_FROM      = 800;
   localparam int unsigned HOLD_OFF_FROM   = 300;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned STALL_LIMIT     = 4000;
   localparam int unsigned DRAIN_CYCLES    = 8;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [7:0]                req_tdata;
   logic                      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [7:0]                rsp_tdata;
   logic [RSP_TUSER_BITS-1:0] rsp_tuser;
   logic                      rsp_tlast;

   tag_event_scoreboard sb = new();

   logic [7:0]  file_bytes[$];
   logic [7:0]  frame_area[$];
   int unsigned live_requests = 0;
   int unsigned gap_odds      = 0;
   int unsigned idle_cycles   = 0;
   bit          quiet         = 1'b0;
   bit          hold_off_due  = 1'b0;

   always #4ns clock = ~clock;

   id3v2_tag_frame_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   task automatic send_byte(input logic [7:0] b, input logic sof);
      if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= sof;
      do @(posedge clock); while (req_tready !== 1'b1);
      // Every accepted request counts, whether or not the parser still reads it.
      void'(sb.note_byte(b, sof));
      live_requests++;
      if (live_requests >= HOLD_OFF_FROM) begin
         hold_off_due = 1'b1;
      end
      if (live_requests >= QUIET_FROM) begin
         quiet = 1'b1;
      end
   endtask

   task automatic send_stream();
      foreach (file_bytes[i]) begin
         send_byte(file_bytes[i], i == 0);
      end
   endtask

   function automatic void push_be32(input logic [31:0] w);
      for (int s = 3; s >= 0; s--) begin
         frame_area.push_back(w[8*s +: 8]);
      end
   endfunction

   // Appends one frame to the frame area. Returns 1 when the frame claims a
   // huge size, so that the file is cut off inside its data.
   function automatic bit add_frame();
      int unsigned pick;
      int unsigned data_len;
      int unsigned descr_len;
      logic [31:0] id;
      logic [31:0] size;
      bit          huge;
      pick = $urandom_range(0, 9);
      if (pick < NUM_TAGS) begin
         id = KNOWN_IDS[pick];
      end else if (pick < 8) begin
         id = KNOWN_IDS[$urandom_range(0, NUM_TAGS - 1)] ^ (32'd1 << $urandom_range(0, 31));
      end else begin
         id = $urandom();
      end
      // Short sizes sit around the one-byte text and four-byte comment limits.
      data_len  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : $urandom_range(2, 20);
      huge      = ($urandom_range(0, 24) == 0);
      size      = huge ? ($urandom() | 32'h0100_0000) : data_len;
      descr_len = $urandom_range(0, 6);
      push_be32(id);
      push_be32(size);
      frame_area.push_back(8'($urandom_range(0, 255)));
      frame_area.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < data_len; i++) begin
         if (id != KNOWN_IDS[TAG_COMM] || i <= COMM_LANG_LAST) begin
            frame_area.push_back(8'($urandom_range(0, 255)));
         end else if (i <= COMM_LANG_LAST + descr_len) begin
            frame_area.push_back(8'($urandom_range(1, 255)));
         end else if (i == COMM_LANG_LAST + descr_len + 1) begin
            frame_area.push_back(8'd0);
         end else begin
            frame_area.push_back(8'($urandom_range(0, 255)));
         end
      end
      return huge;
   endfunction

   function automatic void build_file();
      int unsigned n_frames;
      int unsigned pad;
      int unsigned area_size;
      logic [7:0]  magic [3];
      file_bytes.delete();
      frame_area.delete();
      n_frames = $urandom_range(1, 5);
      for (int i = 0; i < n_frames; i++) begin
         if (add_frame()) begin
            break;
         end
      end
      pad = $urandom_range(0, 4);
      magic = '{ID3_MAGIC[23:16], ID3_MAGIC[15:8], ID3_MAGIC[7:0]};
      if ($urandom_range(0, 7) == 0) begin
         magic[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
      end
      case ($urandom_range(0, 7))
         6: area_size = $urandom_range(0, frame_area.size());
         7: area_size = $urandom_range(0, 28'hFFF_FFFF);
         default: area_size = frame_area.size() + pad;
      endcase
      foreach (magic[i]) begin
         file_bytes.push_back(magic[i]);
      end
      repeat (3) file_bytes.push_back(8'($urandom_range(0, 255)));
      // Synchsafe size: the top bit of each byte is ignored by the parser.
      for (int s = 3; s >= 0; s--) begin
         file_bytes.push_back({($urandom_range(0, 3) == 0), area_size[7*s +: 7]});
      end
      foreach (frame_area[i]) begin
         file_bytes.push_back(frame_area[i]);
      end
      repeat (pad) file_bytes.push_back(8'd0);
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic send_file();
      build_file();
      case ($urandom_range(0, 2))
         0: gap_odds = 0;
         1: gap_odds = 4;
         default: gap_odds = 20;
      endcase
      send_stream();
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 12)) begin
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin : stimulus
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // A header with the wrong letters and extreme size bytes, then a byte
      // that must be ignored.
      file_bytes = '{8'h49, 8'h44, 8'h34, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'hFF, 8'h7F, 8'h80,
                     8'hA5};
      send_stream();
      // A header cut short by the start of the next file.
      file_bytes = '{8'h49, 8'h44, 8'h33, 8'hFF};
      send_stream();
      // An empty tag area stops parsing straight after the header.
      file_bytes = '{8'h49, 8'h44, 8'h33, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h54};
      send_stream();

      while (live_requests < TARGET_BYTES) begin
         if ($urandom_range(0, 9) == 0) begin
            send_noise();
         end else begin
            send_file();
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.final_errors() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : result_side
      bit          held;
      int unsigned stall_odds;
      held       = 1'b0;
      stall_odds = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) begin
            stall_odds = $urandom_range(0, 2) * 6;
         end
         if (hold_off_due && !held) begin
            // Long hold-off while requests keep coming, so the queue fills up.
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         sb.check_event(rsp_event_type'({rsp_tuser[0], rsp_tuser[3:1], rsp_tuser[5:4],
                                         rsp_tuser[6], rsp_tdata, rsp_tlast}));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/id3_pkg.sv
sv/id3_front.sv
sv/id3_queue.sv
sv/id3_back.sv
sv/id3v2_tag_frame_parser.sv
sv/id3_checker.sv
test/tag_event_sb_pkg.sv
test/tb_top.sv
